/* hdl/rcsfr_pkg.sv */
// ----------------------------------------------------------------------------
// rcsfr_pkg
// Shared types and constants for the serial frame receiver.
// ----------------------------------------------------------------------------
package rcsfr_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int VALUE_W  = 16;

    // Input action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_BYTE = 2'd0,
        ACT_IDLE = 2'd1,
        ACT_READ = 2'd2
    } t_action;

    // Result kind codes
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Checksum seed
    localparam logic [VALUE_W-1:0] SUM_INIT = 16'hFFFF;

    // Command kinds passed from the framer to the executor
    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind            kind;
        logic                 match;
        logic [INDEX_W-1:0]   idx;
    } t_cmd_ctl;

endpackage

/* hdl/rcsfr_front.sv */
// ----------------------------------------------------------------------------
// rcsfr_front
// Framer: tracks frame position, running checksum and staged payload, and
// issues frame-complete and channel-read commands.
// ----------------------------------------------------------------------------
module rcsfr_front #(
    parameter int NUM_CHANNELS = 10,
    parameter int FRAME_BYTES  = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_take,
    input  logic [rcsfr_pkg::ACTION_W-1:0]            i_action,
    input  logic [rcsfr_pkg::BYTE_W-1:0]              i_rx_byte,
    input  logic [rcsfr_pkg::INDEX_W-1:0]             i_channel_index,
    output logic                                      o_cmd_valid,
    output rcsfr_pkg::t_cmd_ctl                       o_cmd_ctl,
    output logic [NUM_CHANNELS*rcsfr_pkg::VALUE_W-1:0] o_cmd_data
);

    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int CHECK_LOW    = FRAME_BYTES - 2;
    localparam int CHECK_HIGH   = FRAME_BYTES - 1;
    localparam int PAYLOAD_SPAN = 2 * NUM_CHANNELS;
    localparam int BW           = rcsfr_pkg::BYTE_W;
    localparam int VW           = rcsfr_pkg::VALUE_W;

    logic                 r_armed;
    logic [POS_W-1:0]     r_pos;
    logic [VW-1:0]        r_sum;
    logic [BW-1:0]        r_staged [PAYLOAD_SPAN];
    logic [BW-1:0]        r_check_low;

    logic                 w_byte;
    logic                 w_idle;
    logic                 w_read;
    logic                 w_in_body;
    logic                 w_at_low;
    logic                 w_at_last;

    // Decode the transaction
    assign w_byte    = i_take && (i_action == rcsfr_pkg::ACT_BYTE) && r_armed;
    assign w_idle    = i_take && (i_action == rcsfr_pkg::ACT_IDLE);
    assign w_read    = i_take && (i_action == rcsfr_pkg::ACT_READ);
    assign w_in_body = r_pos < POS_W'(CHECK_LOW);
    assign w_at_low  = r_pos == POS_W'(CHECK_LOW);
    assign w_at_last = r_pos == POS_W'(CHECK_HIGH);

    // Issue a command for reads and for the last byte of a frame
    always_comb begin
        o_cmd_valid     = w_read || (w_byte && w_at_last);
        o_cmd_ctl.kind  = w_read ? rcsfr_pkg::CMD_READ : rcsfr_pkg::CMD_FRAME;
        o_cmd_ctl.match = ({i_rx_byte, r_check_low} == r_sum);
        o_cmd_ctl.idx   = i_channel_index;
    end

    // Assemble channel words from the staged bytes
    for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_data
        if (2 * k + 3 < CHECK_LOW) begin : g_used
            assign o_cmd_data[k*VW +: VW] = {r_staged[2*k+1], r_staged[2*k]};
        end else begin : g_unused
            assign o_cmd_data[k*VW +: VW] = '0;
        end
    end

    // Track framing state and running checksum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_pos   <= '0;
            r_sum   <= rcsfr_pkg::SUM_INIT;
        end else if (w_idle) begin
            r_armed <= 1'b1;
            r_pos   <= '0;
            r_sum   <= rcsfr_pkg::SUM_INIT;
        end else if (w_byte) begin
            if (w_at_last) begin
                r_armed <= 1'b0;
                r_pos   <= '0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (w_in_body) begin
                r_sum <= r_sum - VW'(i_rx_byte);
            end
        end
    end

    // Stage payload bytes and the low checksum byte
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PAYLOAD_SPAN; k++) begin
            if (k + 2 < CHECK_LOW) begin
                if (w_byte && r_pos == POS_W'(k + 2)) begin
                    r_staged[k] <= i_rx_byte;
                end
            end
        end
        if (w_byte && w_at_low) begin
            r_check_low <= i_rx_byte;
        end
    end

endmodule

/* hdl/rcsfr_cmd_queue.sv */
// ----------------------------------------------------------------------------
// rcsfr_cmd_queue
// Two-entry command queue between the framer and the executor.
// ----------------------------------------------------------------------------
module rcsfr_cmd_queue #(
    parameter int WIDTH = 166
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full    = r_count == 2'(DEPTH);
    assign o_valid   = r_count != 2'd0;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Hold queued entries
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* hdl/rcsfr_back.sv */
// ----------------------------------------------------------------------------
// rcsfr_back
// Executor: owns the channel store and error flag, runs commands in order
// and holds the result register.
// ----------------------------------------------------------------------------
module rcsfr_back #(
    parameter int NUM_CHANNELS = 10,
    parameter int FRAME_BYTES  = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cmd_valid,
    input  rcsfr_pkg::t_cmd_ctl                        i_cmd_ctl,
    input  logic [NUM_CHANNELS*rcsfr_pkg::VALUE_W-1:0] i_cmd_data,
    output logic                                       o_cmd_take,
    input  logic                                       i_pop,
    output logic                                       o_empty,
    output logic                                       o_result_kind,
    output logic [rcsfr_pkg::VALUE_W-1:0]              o_channel_value,
    output logic                                       o_checksum_error
);

    localparam int VW        = rcsfr_pkg::VALUE_W;
    localparam int CHECK_LOW = FRAME_BYTES - 2;

    logic [VW-1:0] r_chan [NUM_CHANNELS];
    logic          r_error;
    logic          r_out_valid;
    logic          r_out_kind;
    logic [VW-1:0] r_out_value;
    logic          r_out_error;

    logic [VW-1:0] w_read_value;
    logic          w_commit;

    assign o_cmd_take = i_cmd_valid && (!r_out_valid || i_pop);
    assign w_commit   = o_cmd_take && (i_cmd_ctl.kind == rcsfr_pkg::CMD_FRAME)
                        && i_cmd_ctl.match;

    // Select the requested channel
    always_comb begin
        w_read_value = '0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (i_cmd_ctl.idx == rcsfr_pkg::INDEX_W'(k)) begin
                w_read_value = r_chan[k];
            end
        end
    end

    // Commit channels and update the error flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_chan[k] <= '0;
            end
            r_error <= 1'b0;
        end else if (o_cmd_take && i_cmd_ctl.kind == rcsfr_pkg::CMD_FRAME) begin
            r_error <= !i_cmd_ctl.match;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                if (w_commit && (2 * k + 3 < CHECK_LOW)) begin
                    r_chan[k] <= i_cmd_data[k*VW +: VW];
                end
            end
        end
    end

    // Load and drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_take) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            unique case (i_cmd_ctl.kind)
                rcsfr_pkg::CMD_READ: begin
                    r_out_kind  <= rcsfr_pkg::KIND_READ;
                    r_out_value <= w_read_value;
                    r_out_error <= r_error;
                end
                default: begin
                    r_out_kind  <= rcsfr_pkg::KIND_STATUS;
                    r_out_value <= '0;
                    r_out_error <= !i_cmd_ctl.match;
                end
            endcase
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_result_kind    = r_out_kind;
    assign o_channel_value  = r_out_value;
    assign o_checksum_error = r_out_error;

endmodule

/* hdl/rc_serial_frame_receiver.sv */
// ----------------------------------------------------------------------------
// rc_serial_frame_receiver
// Byte-serial remote-control frame receiver with channel readback.
// ----------------------------------------------------------------------------
// One transaction per clock is accepted while full is low. An idle action
// arms the receiver and restarts the frame; bytes then fill a FRAME_BYTES
// frame whose last two bytes carry the checksum. The last byte yields a status
// result and, on a checksum match, commits NUM_CHANNELS little-endian channels.
// A read action yields the channel value (0 past NUM_CHANNELS) with the current
// error flag. The framer writes a two-entry command queue at the accepting
// clock, and the executor moves one command per clock into the result register
// when that register is free or being popped, so a result passes through the
// command queue to the result register that drives the outputs. full rises
// only when the command queue holds two commands behind an unpopped result.
module rc_serial_frame_receiver #(
    parameter int NUM_CHANNELS = 10,
    parameter int FRAME_BYTES  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [rcsfr_pkg::ACTION_W-1:0]    i_action,
    input  logic [rcsfr_pkg::BYTE_W-1:0]      i_rx_byte,
    input  logic [rcsfr_pkg::INDEX_W-1:0]     i_channel_index,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_result_kind,
    output logic [rcsfr_pkg::VALUE_W-1:0]     o_channel_value,
    output logic                              o_checksum_error
);

    localparam int DATA_W = NUM_CHANNELS * rcsfr_pkg::VALUE_W;
    localparam int CTL_W  = $bits(rcsfr_pkg::t_cmd_ctl);

    logic                 w_take;
    logic                 w_cmd_wr;
    rcsfr_pkg::t_cmd_ctl  w_wr_ctl;
    logic [DATA_W-1:0]    w_wr_data;
    logic                 w_q_valid;
    logic [CTL_W+DATA_W-1:0] w_q_data;
    rcsfr_pkg::t_cmd_ctl  w_rd_ctl;
    logic                 w_cmd_take;

    assign w_take   = push && !full;
    assign w_rd_ctl = rcsfr_pkg::t_cmd_ctl'(w_q_data[CTL_W+DATA_W-1:DATA_W]);

    rcsfr_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .FRAME_BYTES  (FRAME_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_action        (i_action),
        .i_rx_byte       (i_rx_byte),
        .i_channel_index (i_channel_index),
        .o_cmd_valid     (w_cmd_wr),
        .o_cmd_ctl       (w_wr_ctl),
        .o_cmd_data      (w_wr_data)
    );

    rcsfr_cmd_queue #(
        .WIDTH (CTL_W + DATA_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_cmd_wr),
        .i_wr_data ({w_wr_ctl, w_wr_data}),
        .i_rd      (w_cmd_take),
        .o_full    (full),
        .o_valid   (w_q_valid),
        .o_rd_data (w_q_data)
    );

    rcsfr_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .FRAME_BYTES  (FRAME_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (w_q_valid),
        .i_cmd_ctl        (w_rd_ctl),
        .i_cmd_data       (w_q_data[DATA_W-1:0]),
        .o_cmd_take       (w_cmd_take),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_result_kind    (o_result_kind),
        .o_channel_value  (o_channel_value),
        .o_checksum_error (o_checksum_error)
    );

endmodule

/* hdl/rcsfr_checker.sv */
// ----------------------------------------------------------------------------
// rcsfr_checker
// Port-level checks for the serial frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module rcsfr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic                          o_result_kind,
    input logic [rcsfr_pkg::VALUE_W-1:0] o_channel_value
);

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // Reset leaves the input open
    a_reset_open: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked after reset");

    // Status results carry a zero channel value
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == rcsfr_pkg::KIND_STATUS) |-> o_channel_value == '0)
        else $error("status result with nonzero channel value");

    // Hold a waiting result until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_channel_value)
                              && $stable(o_result_kind)))
        else $error("waiting result changed");

endmodule

bind rc_serial_frame_receiver rcsfr_checker u_chk (.*);
